// File: rtl/cpwe_pkg.sv
// shared types and constants for the cassette pulse-width encoder
// no dependencies; imported by every module of the block
package cpwe_pkg;

  localparam int PairsPerItem = 32;
  localparam int UnitWidth    = 16;
  localparam int DurWidth     = 18;
  localparam int IdxWidth     = 6;
  localparam int SumWidth     = 16;
  localparam int ByteWidth    = 8;
  localparam int CountWidth   = 6;

  typedef enum logic [1:0] {
    ACT_DATA  = 2'd0,
    ACT_PILOT = 2'd1,
    ACT_SYNC  = 2'd2,
    ACT_CSUM  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    UNITS_ONE   = 2'd1,
    UNITS_TWO   = 2'd2,
    UNITS_THREE = 2'd3
  } units_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } seq_state_t;

  typedef struct packed {
    logic                level;
    logic [DurWidth-1:0] duration;
    logic                last;
  } pulse_t;

  localparam logic [CountWidth-1:0] PairsMax = CountWidth'(PairsPerItem);
  localparam logic [IdxWidth-1:0]   DataLastIdx = IdxWidth'(4 * ByteWidth - 1);
  localparam logic [IdxWidth-1:0]   CsumLastIdx = IdxWidth'(8 * ByteWidth - 1);
  localparam logic [IdxWidth-1:0]   SyncLastIdx = IdxWidth'(5);

  localparam logic REG_UNIT = 1'b0;

endpackage

// File: rtl/cpwe_csum.sv
// running 16-bit end-around-carry checksum of flagged data bytes
// depends on cpwe_pkg
module cpwe_csum
  import cpwe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 add,
  input  logic                 clear,
  input  logic [ByteWidth-1:0] data_byte,
  output logic [SumWidth-1:0]  sum
);

  logic [SumWidth:0] sum_wide;

  assign sum_wide = {1'b0, sum} + {{(SumWidth + 1 - ByteWidth){1'b0}}, data_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (clear) begin
      sum <= '0;
    end else if (add) begin
      // carry out folds back into bit 0
      sum <= sum_wide[SumWidth-1:0] + {{(SumWidth - 1){1'b0}}, sum_wide[SumWidth]};
    end
  end

endmodule

// File: rtl/cpwe_seq.sv
// half-period sequencer: shifts the byte or checksum out one bit per four pulses
// depends on cpwe_pkg
module cpwe_seq
  import cpwe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  action_t               action,
  input  logic [ByteWidth-1:0]  data_byte,
  input  logic [CountWidth-1:0] pair_count,
  input  logic [SumWidth-1:0]   sum,
  input  logic [UnitWidth-1:0]  half_unit_ticks,
  input  logic                  advance,
  output logic                  idle,
  output logic                  valid,
  output pulse_t                pulse
);

  seq_state_t              state;
  action_t                 kind;
  logic [SumWidth-1:0]     bits;
  logic [IdxWidth-1:0]     idx;
  logic [IdxWidth-1:0]     last_idx;
  logic [DurWidth-1:0]     unit1;
  logic [DurWidth-1:0]     unit2;
  logic [DurWidth-1:0]     unit3;
  logic [IdxWidth-1:0]     last_idx_next;
  logic [CountWidth-1:0]   pairs_sat;
  logic [CountWidth-1:0]   pairs_m1;
  logic [DurWidth-1:0]     unit_base;
  logic                    go;
  units_t                  units;

  assign pairs_sat = (pair_count > PairsMax) ? PairsMax : pair_count;
  assign pairs_m1  = pairs_sat - CountWidth'(1);
  assign unit_base = (half_unit_ticks == '0) ? DurWidth'(1)
                                             : {{(DurWidth - UnitWidth){1'b0}}, half_unit_ticks};

  always_comb begin
    last_idx_next = DataLastIdx;
    go            = 1'b1;
    case (action)
      ACT_DATA:  last_idx_next = DataLastIdx;
      ACT_PILOT: begin
        last_idx_next = {pairs_m1[IdxWidth-2:0], 1'b1};
        go            = (pair_count != '0);
      end
      ACT_SYNC:  last_idx_next = SyncLastIdx;
      ACT_CSUM:  last_idx_next = CsumLastIdx;
      default:   last_idx_next = DataLastIdx;
    endcase
  end

  always_comb begin
    units = UNITS_ONE;
    case (kind)
      ACT_DATA, ACT_CSUM: units = (!idx[1] && bits[0]) ? UNITS_TWO : UNITS_ONE;
      ACT_PILOT:          units = UNITS_ONE;
      ACT_SYNC: begin
        case (idx[2:1])
          2'd0:    units = UNITS_THREE;
          2'd1:    units = UNITS_TWO;
          default: units = UNITS_ONE;
        endcase
      end
      default:            units = UNITS_ONE;
    endcase
  end

  always_comb begin
    pulse.level = idx[0];
    pulse.last  = (idx == last_idx);
    case (units)
      UNITS_THREE: pulse.duration = unit3;
      UNITS_TWO:   pulse.duration = unit2;
      default:     pulse.duration = unit1;
    endcase
  end

  assign idle  = (state == ST_IDLE);
  assign valid = (state == ST_BUSY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start && go) begin
            state <= ST_BUSY;
            idx   <= '0;
          end
        end
        ST_BUSY: begin
          if (advance) begin
            if (pulse.last) begin
              state <= ST_IDLE;
            end
            idx <= idx + IdxWidth'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (start && idle) begin
      kind     <= action;
      last_idx <= last_idx_next;
      bits     <= (action == ACT_CSUM) ? sum
                                       : {{(SumWidth - ByteWidth){1'b0}}, data_byte};
      unit1    <= unit_base;
      unit2    <= {unit_base[DurWidth-2:0], 1'b0};
      unit3    <= unit_base + {unit_base[DurWidth-2:0], 1'b0};
    end else if (valid && advance && (idx[1:0] == 2'd3)) begin
      bits <= {1'b0, bits[SumWidth-1:1]};
    end
  end

endmodule

// File: rtl/cassette_pulse_width_encoder.sv
// top level of the cassette pulse-width encoder: stream ports, register port,
// output register; depends on cpwe_pkg, cpwe_csum and cpwe_seq
//
// Usage: an input request on s_* carries one tape item, the kind of item in
// s_tuser. The block answers with a train of half-period pulses on m_*, one
// request each, m_tlast marking the final pulse of the item. A data byte gives
// 32 pulses, a checksum emit 64, a sync marker 6, a pilot item two per pair
// (a pair count of zero gives none, counts above 32 are taken as 32).
// Taking an item sets the sequencer state register; the first pulse then
// passes into the output register. The bit-serial sequencer gives one pulse
// per cycle while the receiver does not stall; s_tready is low while an item
// is being sent. When the receiver stalls, the output register holds its
// pulse and the sequencer waits. half_unit_ticks is to be written through
// the register port (addresses 0 to 3) only while the block is idle, which
// it does not enforce; a value of 0 acts as 1. Reset empties the output,
// idles the sequencer, clears the checksum and sets half_unit_ticks to 100.
module cassette_pulse_width_encoder
  import cpwe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_byte[7:0], add_to_sum[8], pair_count[14:9], zero
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // level[0], duration_ticks[18:1], zero
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [UnitWidth-1:0]  half_unit_ticks;
  logic                  start;
  logic                  seq_idle;
  logic                  seq_valid;
  logic                  advance;
  logic                  out_free;
  action_t               action;
  logic [ByteWidth-1:0]  data_byte;
  logic                  add_to_sum;
  logic [CountWidth-1:0] pair_count;
  logic [SumWidth-1:0]   sum;
  pulse_t                pulse;
  pulse_t                out_pulse;

  assign action     = action_t'(s_tuser);
  assign data_byte  = s_tdata[7:0];
  assign add_to_sum = s_tdata[8];
  assign pair_count = s_tdata[14:9];

  assign s_tready = seq_idle;
  assign start    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign advance  = seq_valid && out_free;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_UNIT) ? {{(32 - UnitWidth){1'b0}}, half_unit_ticks} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_unit_ticks <= UnitWidth'(100);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_UNIT)) begin
      half_unit_ticks <= pwdata[UnitWidth-1:0];
    end
  end

  cpwe_csum u_csum (
    .clk       (clk),
    .rst       (rst),
    .add       (start && (action == ACT_DATA) && add_to_sum),
    .clear     (start && (action == ACT_CSUM)),
    .data_byte (data_byte),
    .sum       (sum)
  );

  cpwe_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .action          (action),
    .data_byte       (data_byte),
    .pair_count      (pair_count),
    .sum             (sum),
    .half_unit_ticks (half_unit_ticks),
    .advance         (advance),
    .idle            (seq_idle),
    .valid           (seq_valid),
    .pulse           (pulse)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= seq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pulse <= pulse;
    end
  end

  assign m_tdata = {{(24 - DurWidth - 1){1'b0}}, out_pulse.duration, out_pulse.level};
  assign m_tlast = out_pulse.last;

endmodule
